FILE: src/arm_alu_pkg.sv
// shared types, widths and opcode constants of the data-processing alu
package arm_alu_pkg;

    localparam int unsigned S_TDATA_W = 96;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned WORD_W    = 32;

    // flag bit positions in the packed n z c v nibble
    localparam int unsigned FLAG_N_BIT = 3;
    localparam int unsigned FLAG_Z_BIT = 2;
    localparam int unsigned FLAG_C_BIT = 1;
    localparam int unsigned FLAG_V_BIT = 0;

    // data-processing opcodes
    typedef enum logic [3:0] {
        OP_AND = 4'b0000,
        OP_EOR = 4'b0001,
        OP_SUB = 4'b0010,
        OP_RSB = 4'b0011,
        OP_ADD = 4'b0100,
        OP_ADC = 4'b0101,
        OP_SBC = 4'b0110,
        OP_RSC = 4'b0111,
        OP_TST = 4'b1000,
        OP_TEQ = 4'b1001,
        OP_CMP = 4'b1010,
        OP_CMN = 4'b1011,
        OP_ORR = 4'b1100,
        OP_MOV = 4'b1101,
        OP_BIC = 4'b1110,
        OP_MVN = 4'b1111
    } op_t;

    // shift type field of the instruction
    typedef enum logic [1:0] {
        SHT_LSL = 2'b00,
        SHT_LSR = 2'b01,
        SHT_ASR = 2'b10,
        SHT_ROR = 2'b11
    } sht_t;

    // decoded barrel shifter operation
    typedef enum logic [2:0] {
        SHK_PASS = 3'd0,
        SHK_LSL  = 3'd1,
        SHK_LSR  = 3'd2,
        SHK_ASR  = 3'd3,
        SHK_ROR  = 3'd4,
        SHK_RRX  = 3'd5
    } shk_t;

    // control that travels with each instruction
    typedef struct packed {
        op_t        op;
        logic       upd_flags;
        logic       write_result;
        logic       restore;
        logic [3:0] flags_in;
    } ctl_t;

    // decode stage output
    typedef struct packed {
        ctl_t              ctl;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] src;
        shk_t              kind;
        logic [7:0]        amount;
    } dec_t;

    // shift stage output
    typedef struct packed {
        ctl_t              ctl;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              sc;
    } shf_t;

    // execute stage output
    typedef struct packed {
        ctl_t              ctl;
        logic [WORD_W-1:0] r;
        logic              c;
        logic              v;
    } exe_t;

endpackage

FILE: src/arm_alu_decode.sv
// decode stage: operand 2 source, shift kind and amount, instruction control
module arm_alu_decode (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [3:0]                         op,
    input  logic                               set_flags,
    input  logic                               dest_is_pc,
    input  logic [arm_alu_pkg::WORD_W-1:0]     operand_a,
    input  logic [arm_alu_pkg::WORD_W-1:0]     operand_b_reg,
    input  logic                               immediate_form,
    input  logic [11:0]                        operand2_field,
    input  logic [7:0]                         shift_reg_byte,
    input  logic [3:0]                         flags_in,
    input  logic                               privileged,
    output logic                               out_valid,
    output arm_alu_pkg::dec_t                  out_dec
);
    import arm_alu_pkg::*;

    logic valid_reg;
    dec_t dec_reg;
    dec_t dec_next;
    shk_t type_kind;
    sht_t sh_type;
    logic [4:0] imm_amount;

    assign sh_type    = sht_t'(operand2_field[6:5]);
    assign imm_amount = operand2_field[11:7];

    // map the instruction shift type onto a shifter operation
    always_comb begin
        case (sh_type)
            SHT_LSL: type_kind = SHK_LSL;
            SHT_LSR: type_kind = SHK_LSR;
            SHT_ASR: type_kind = SHK_ASR;
            SHT_ROR: type_kind = SHK_ROR;
            default: type_kind = SHK_PASS;
        endcase
    end

    // operand 2 decode and control bits
    always_comb begin
        dec_next                  = '0;
        dec_next.ctl.op           = op_t'(op);
        dec_next.ctl.upd_flags    = set_flags & ~dest_is_pc;
        dec_next.ctl.write_result = ~(op_t'(op) inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
        dec_next.ctl.restore      = set_flags & dest_is_pc & privileged;
        dec_next.ctl.flags_in     = flags_in;
        dec_next.a                = operand_a;
        if (immediate_form) begin
            // rotated 8-bit immediate
            dec_next.src    = {24'd0, operand2_field[7:0]};
            dec_next.amount = {3'd0, operand2_field[11:8], 1'b0};
            dec_next.kind   = (operand2_field[11:8] == 4'd0) ? SHK_PASS : SHK_ROR;
        end else if (operand2_field[4]) begin
            // shift by register byte
            dec_next.src    = operand_b_reg;
            dec_next.amount = shift_reg_byte;
            dec_next.kind   = (shift_reg_byte == 8'd0) ? SHK_PASS : type_kind;
        end else begin
            // shift by immediate, zero amount has special meanings
            dec_next.src    = operand_b_reg;
            dec_next.amount = {3'd0, imm_amount};
            dec_next.kind   = type_kind;
            if (imm_amount == 5'd0) begin
                case (sh_type)
                    SHT_LSL: dec_next.kind = SHK_PASS;
                    SHT_ROR: dec_next.kind = SHK_RRX;
                    default: dec_next.amount = 8'd32;
                endcase
            end
        end
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dec_reg <= dec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

endmodule

FILE: src/arm_alu_shift.sv
// shift stage: barrel shifter producing operand 2 and the shifter carry
module arm_alu_shift (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  arm_alu_pkg::dec_t in_dec,
    output logic              out_valid,
    output arm_alu_pkg::shf_t out_shf
);
    import arm_alu_pkg::*;

    logic              valid_reg;
    shf_t              shf_reg;
    shf_t              shf_next;
    logic [WORD_W:0]   lsl_w;
    logic [WORD_W:0]   lsr_w;
    logic signed [WORD_W:0] asr_w;
    logic [2*WORD_W-1:0] ror_w;
    logic              cin;

    assign cin = in_dec.ctl.flags_in[FLAG_C_BIT];

    // extra bit on the far side of the lsl, lsr and asr shifts catches the carry out
    assign lsl_w = {1'b0, in_dec.src} << in_dec.amount;
    assign lsr_w = {in_dec.src, 1'b0} >> in_dec.amount;
    assign asr_w = $signed({in_dec.src, 1'b0}) >>> in_dec.amount;
    assign ror_w = {in_dec.src, in_dec.src} >> in_dec.amount[4:0];

    always_comb begin
        shf_next     = '0;
        shf_next.ctl = in_dec.ctl;
        shf_next.a   = in_dec.a;
        case (in_dec.kind)
            SHK_LSL: begin
                shf_next.b  = lsl_w[WORD_W-1:0];
                shf_next.sc = lsl_w[WORD_W];
            end
            SHK_LSR: begin
                shf_next.b  = lsr_w[WORD_W:1];
                shf_next.sc = lsr_w[0];
            end
            SHK_ASR: begin
                shf_next.b  = asr_w[WORD_W:1];
                shf_next.sc = asr_w[0];
            end
            SHK_ROR: begin
                shf_next.b  = ror_w[WORD_W-1:0];
                shf_next.sc = ror_w[WORD_W-1];
            end
            SHK_RRX: begin
                shf_next.b  = {cin, in_dec.src[WORD_W-1:1]};
                shf_next.sc = in_dec.src[0];
            end
            default: begin
                shf_next.b  = in_dec.src;
                shf_next.sc = cin;
            end
        endcase
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            shf_reg <= shf_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_shf   = shf_reg;

endmodule

FILE: src/arm_alu_exec.sv
// execute stage: logic operations and the 32-bit adder with carry and overflow
module arm_alu_exec (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  arm_alu_pkg::shf_t in_shf,
    output logic              out_valid,
    output arm_alu_pkg::exe_t out_exe
);
    import arm_alu_pkg::*;

    logic              valid_reg;
    exe_t              exe_reg;
    exe_t              exe_next;
    logic [WORD_W-1:0] add_x;
    logic [WORD_W-1:0] add_y;
    logic              add_ci;
    logic [WORD_W:0]   sum;
    logic              cin;

    assign cin = in_shf.ctl.flags_in[FLAG_C_BIT];

    // adder operand selection
    always_comb begin
        case (in_shf.ctl.op)
            OP_SUB, OP_CMP: begin
                add_x = in_shf.a;  add_y = ~in_shf.b; add_ci = 1'b1;
            end
            OP_RSB: begin
                add_x = in_shf.b;  add_y = ~in_shf.a; add_ci = 1'b1;
            end
            OP_ADC: begin
                add_x = in_shf.a;  add_y = in_shf.b;  add_ci = cin;
            end
            OP_SBC: begin
                add_x = in_shf.a;  add_y = ~in_shf.b; add_ci = cin;
            end
            OP_RSC: begin
                add_x = in_shf.b;  add_y = ~in_shf.a; add_ci = cin;
            end
            default: begin
                add_x = in_shf.a;  add_y = in_shf.b;  add_ci = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + {{WORD_W{1'b0}}, add_ci};

    // result select, logic ops take carry from the shifter and keep v
    always_comb begin
        exe_next     = '0;
        exe_next.ctl = in_shf.ctl;
        exe_next.c   = in_shf.sc;
        exe_next.v   = in_shf.ctl.flags_in[FLAG_V_BIT];
        case (in_shf.ctl.op)
            OP_AND, OP_TST: exe_next.r = in_shf.a & in_shf.b;
            OP_EOR, OP_TEQ: exe_next.r = in_shf.a ^ in_shf.b;
            OP_ORR:         exe_next.r = in_shf.a | in_shf.b;
            OP_MOV:         exe_next.r = in_shf.b;
            OP_BIC:         exe_next.r = in_shf.a & ~in_shf.b;
            OP_MVN:         exe_next.r = ~in_shf.b;
            default: begin
                exe_next.r = sum[WORD_W-1:0];
                exe_next.c = sum[WORD_W];
                exe_next.v = ((add_x[WORD_W-1] ^ sum[WORD_W-1])
                            & (add_y[WORD_W-1] ^ sum[WORD_W-1]));
            end
        endcase
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            exe_reg <= exe_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_exe   = exe_reg;

endmodule

FILE: src/arm_data_processing_alu_core.sv
// top level: arm data-processing alu, four-stage pipeline with stream ports
// an input transfer reaches result valid through the decode, shift,
// execute and flags/output registers; throughput: one instruction per cycle unless stalled.
// the whole pipeline advances together whenever the output register is
// empty or being taken, so s_tready follows m_tready or an empty output.
// reset (aresetn low, synchronous) clears all stage valid bits.
module arm_data_processing_alu_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // op[3:0] set_flags[4] dest_is_pc[5] operand_a[37:6] operand_b_reg[69:38]
    // operand2_field[81:70] shift_reg_byte[89:82] flags_in[93:90]
    // privileged[94] zero[95]
    input  logic [arm_alu_pkg::S_TDATA_W-1:0]   s_tdata,
    // immediate_form[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result[31:0] write_result[32] flags_out[36:33] restore_status[37]
    // zero[39:38]
    output logic [arm_alu_pkg::M_TDATA_W-1:0]   m_tdata
);
    import arm_alu_pkg::*;

    logic                 en;
    logic                 dec_valid;
    dec_t                 dec;
    logic                 shf_valid;
    shf_t                 shf;
    logic                 exe_valid;
    exe_t                 exe;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [3:0]           flags_next;

    // global advance: output slot free or being taken
    assign en       = ~m_tvalid_reg | m_tready;
    assign s_tready = en;

    arm_alu_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_tvalid),
        .op             (s_tdata[3:0]),
        .set_flags      (s_tdata[4]),
        .dest_is_pc     (s_tdata[5]),
        .operand_a      (s_tdata[37:6]),
        .operand_b_reg  (s_tdata[69:38]),
        .immediate_form (s_tuser),
        .operand2_field (s_tdata[81:70]),
        .shift_reg_byte (s_tdata[89:82]),
        .flags_in       (s_tdata[93:90]),
        .privileged     (s_tdata[94]),
        .out_valid      (dec_valid),
        .out_dec        (dec)
    );

    arm_alu_shift u_shift (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dec_valid),
        .in_dec    (dec),
        .out_valid (shf_valid),
        .out_shf   (shf)
    );

    arm_alu_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (shf_valid),
        .in_shf    (shf),
        .out_valid (exe_valid),
        .out_exe   (exe)
    );

    // flag update: n z c v from the result, or pass through
    always_comb begin
        if (exe.ctl.upd_flags) begin
            flags_next[FLAG_N_BIT] = exe.r[WORD_W-1];
            flags_next[FLAG_Z_BIT] = (exe.r == {WORD_W{1'b0}});
            flags_next[FLAG_C_BIT] = exe.c;
            flags_next[FLAG_V_BIT] = exe.v;
        end else begin
            flags_next = exe.ctl.flags_in;
        end
    end

    assign m_tdata_next = {2'b00, exe.ctl.restore, flags_next,
                           exe.ctl.write_result, exe.r};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= exe_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: src/arm_alu_checker.sv
// port-level checker for the data-processing alu and its bind
module arm_alu_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [arm_alu_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [arm_alu_pkg::M_TDATA_W-1:0] m_tdata
);
    import arm_alu_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input is taken whenever the output side moves or is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input blocked while pipeline can advance");

    // an accepted instruction reaches the output while m_tready stays high
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == s_tuser && s_tdata == s_tdata)
        ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind arm_data_processing_alu_core arm_alu_checker u_arm_alu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
